/* hw/rtl/latency_histogram_counters_macros.svh */
// Assertion macros for the latency histogram counters.
// Each expects clk and arst_n in scope at the point of use.
`ifndef LATENCY_HISTOGRAM_COUNTERS_MACROS_SVH
`define LATENCY_HISTOGRAM_COUNTERS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LHC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("latency histogram assertion failed");

// antecedent implies consequent in the next cycle
`define LHC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("latency histogram assertion failed");

`endif

/* hw/rtl/lhc_pkg.sv */
// Shared types and constants for the latency histogram counters.
// Holds word structs, controller command and status structs, the bound ladder, op codes and the status class function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lhc_pkg;

	localparam int CLASS_COUNT = 6;
	localparam int LADDER_LEN  = 32;

	localparam logic [1:0] OP_RECORD   = 2'd0;
	localparam logic [1:0] OP_READ_REQ = 2'd1;
	localparam logic [1:0] OP_READ_BKT = 2'd2;
	localparam logic [1:0] OP_READ_TOT = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  method;
		logic [9:0]  status;
		logic [31:0] duration_us;
		logic [2:0]  class_select;
		logic [3:0]  bucket_select;
	} lhc_in_t;

	typedef struct packed {
		logic [63:0] counter_value;
		logic [63:0] total_requests;
		logic [63:0] duration_sum_us;
	} lhc_out_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic decode;
		logic read;
		logic update;
		logic emit;
	} lhc_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} lhc_stat_t;

	localparam logic [63:0] BOUND_LADDER [0:LADDER_LEN-1] = '{
		64'd500, 64'd1000, 64'd2500, 64'd5000,
		64'd10000, 64'd25000, 64'd50000,
		64'd100000, 64'd250000, 64'd500000,
		64'd1000000, 64'd2500000, 64'd5000000,
		64'd10000000, 64'd25000000, 64'd50000000,
		64'd100000000, 64'd250000000, 64'd500000000,
		64'd1000000000, 64'd2500000000, 64'd5000000000,
		64'd10000000000, 64'd25000000000, 64'd50000000000,
		64'd100000000000, 64'd250000000000, 64'd500000000000,
		64'd1000000000000, 64'd2500000000000, 64'd5000000000000,
		64'd10000000000000
	};

	// status / 100, classes of six and up fold to zero
	function automatic logic [2:0] status_class(input logic [9:0] status);
		logic [2:0] cls;
		if (status < 10'd100) begin
			cls = 3'd0;
		end else if (status < 10'd200) begin
			cls = 3'd1;
		end else if (status < 10'd300) begin
			cls = 3'd2;
		end else if (status < 10'd400) begin
			cls = 3'd3;
		end else if (status < 10'd500) begin
			cls = 3'd4;
		end else if (status < 10'd600) begin
			cls = 3'd5;
		end else begin
			cls = 3'd0;
		end
		return cls;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/lhc_ctrl.sv */
// Controller state machine for the latency histogram counters.
// Sequences clear pass, decode, read, update and result load.
// Depends on lhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_valid,
	output logic              rec_stall,
	input  lhc_pkg::lhc_stat_t stat,
	output lhc_pkg::lhc_cmd_t  cmd
);
	import lhc_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		rec_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rec_stall = 1'b0;
				if (rec_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/lhc_datapath.sv */
// Datapath for the latency histogram counters: request counter memory,
// bucket counters, totals and the result register. Depends on lhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhc_datapath #(
	parameter int METHOD_COUNT = 16,
	parameter int BUCKET_COUNT = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lhc_pkg::lhc_in_t  rec_data,
	input  lhc_pkg::lhc_cmd_t cmd,
	output lhc_pkg::lhc_stat_t stat,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lhc_pkg::lhc_out_t rsp_data
);
	import lhc_pkg::*;

	localparam int REQ_DEPTH = METHOD_COUNT * CLASS_COUNT;
	localparam int ADDR_W    = $clog2(REQ_DEPTH);
	localparam int MIDX_W    = $clog2(METHOD_COUNT);
	localparam int BIDX_W    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

	lhc_in_t           word_q;
	logic [ADDR_W-1:0] req_addr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [BIDX_W-1:0] bkt_idx_q;
	logic              bkt_ok_q;
	logic [63:0]       req_mem [0:REQ_DEPTH-1];
	logic [63:0]       req_rd_q;
	logic [63:0]       bkt_cnt_q [0:BUCKET_COUNT-1];
	logic [63:0]       bkt_rd_q;
	logic [63:0]       total_q;
	logic [63:0]       sum_q;
	logic [63:0]       value_q;
	logic              rsp_valid_q;
	lhc_out_t          rsp_data_q;

	logic [MIDX_W-1:0] method_idx;
	logic [2:0]        class_idx;
	logic [BIDX_W-1:0] hit_idx;
	logic              hit_any;
	logic              bsel_ok;
	logic [ADDR_W-1:0] req_addr_d;
	logic              is_record;

	assign is_record = (word_q.op == OP_RECORD);

	always_comb begin
		if (int'(word_q.method) >= METHOD_COUNT) begin
			method_idx = MIDX_W'(METHOD_COUNT - 1);
		end else begin
			method_idx = MIDX_W'(word_q.method);
		end
		if (is_record) begin
			class_idx = status_class(word_q.status);
		end else if (word_q.class_select < 3'(CLASS_COUNT)) begin
			class_idx = word_q.class_select;
		end else begin
			class_idx = 3'd0;
		end
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = BUCKET_COUNT - 1; i >= 0; i--) begin
			if ({32'd0, word_q.duration_us} <= BOUND_LADDER[i]) begin
				hit_any = 1'b1;
				hit_idx = BIDX_W'(i);
			end
		end
		bsel_ok    = int'(word_q.bucket_select) < BUCKET_COUNT;
		req_addr_d = (ADDR_W'(method_idx) << 2) + (ADDR_W'(method_idx) << 1)
			+ ADDR_W'(class_idx);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= rec_data;
		end
		if (cmd.decode) begin
			req_addr_q <= req_addr_d;
			if (is_record) begin
				bkt_idx_q <= hit_idx;
				bkt_ok_q  <= hit_any;
			end else if (word_q.op == OP_READ_BKT && bsel_ok) begin
				bkt_idx_q <= BIDX_W'(word_q.bucket_select);
				bkt_ok_q  <= 1'b1;
			end else begin
				bkt_idx_q <= '0;
				bkt_ok_q  <= 1'b0;
			end
		end
		if (cmd.read) begin
			bkt_rd_q <= bkt_cnt_q[bkt_idx_q];
		end
		if (cmd.update) begin
			case (word_q.op)
				OP_READ_REQ: value_q <= req_rd_q;
				OP_READ_BKT: value_q <= bkt_ok_q ? bkt_rd_q : 64'd0;
				default:     value_q <= 64'd0;
			endcase
		end
		if (cmd.emit) begin
			rsp_data_q.counter_value   <= value_q;
			rsp_data_q.total_requests  <= total_q;
			rsp_data_q.duration_sum_us <= sum_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			req_mem[clr_addr_q] <= 64'd0;
		end else if (cmd.update && is_record) begin
			req_mem[req_addr_q] <= req_rd_q + 64'd1;
		end
		if (cmd.read) begin
			req_rd_q <= req_mem[req_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear && !stat.clear_last) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKET_COUNT; i++) begin
				bkt_cnt_q[i] <= 64'd0;
			end
			total_q <= 64'd0;
			sum_q   <= 64'd0;
		end else if (cmd.update && is_record) begin
			if (bkt_ok_q) begin
				bkt_cnt_q[bkt_idx_q] <= bkt_rd_q + 64'd1;
			end
			total_q <= total_q + 64'd1;
			sum_q   <= sum_q + {32'd0, word_q.duration_us};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.clear_last = (clr_addr_q == ADDR_W'(REQ_DEPTH - 1));
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid       = rsp_valid_q;
	assign rsp_data        = rsp_data_q;

endmodule

`default_nettype wire

/* hw/rtl/latency_histogram_counters.sv */
// Top level of the latency histogram counters: controller plus datapath.
// Depends on lhc_pkg, lhc_ctrl, lhc_datapath and the assertion macro header.
//
//   channel | signals                       | word
//   rec     | rec_valid, rec_stall, rec_data | lhc_in_t: op, method, status, duration, selects
//   rsp     | rsp_valid, rsp_stall, rsp_data | lhc_out_t: counter value, total, duration sum
//
// After acceptance each word passes through decode, counter memory read, read-modify-write
// update and a result register load before the next word is accepted.
// After reset all METHOD_COUNT * 6 entries of the request counter memory are cleared, with
// rec_stall high throughout. Bucket counters and totals clear at reset directly.
// A stalled result holds; the next word may be taken while it waits, and its
// result loads once the held one is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "latency_histogram_counters_macros.svh"

module latency_histogram_counters #(
	parameter int METHOD_COUNT = 16,
	parameter int BUCKET_COUNT = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_valid,
	output logic              rec_stall,
	input  lhc_pkg::lhc_in_t  rec_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lhc_pkg::lhc_out_t rsp_data
);
	import lhc_pkg::*;

	lhc_cmd_t  cmd;
	lhc_stat_t stat;

	lhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lhc_datapath #(
		.METHOD_COUNT (METHOD_COUNT),
		.BUCKET_COUNT (BUCKET_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_data  (rec_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	`LHC_ASSERT_NXT(a_busy_after_accept, rec_valid && !rec_stall, rec_stall)
	`LHC_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd))
	`LHC_ASSERT_IMP(a_rsp_from_emit, $rose(rsp_valid), $past(cmd.emit))
	`LHC_ASSERT_IMP(a_no_accept_in_clear, cmd.clear, rec_stall)

endmodule

`default_nettype wire
